@@ hw/rtl/eil4p_pkg.sv @@
// Shared types and constants for the Ethernet / IPv4 / layer-4 header parser.
// Holds status and layer-4 codes, header constants and the captured-header snapshot.
// No dependencies.
package eil4p_pkg;

  // default width of the saturating byte counter
  localparam int COUNT_BITS_DEF = 16;

  // header sizes and field values
  localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
  localparam logic [15:0] IP_MIN_HDR     = 16'd20;
  localparam logic [15:0] TCP_MIN_HDR    = 16'd20;
  localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam int          MF_BIT         = 13;

  // frame byte positions of captured fields
  localparam int POS_ETYPE_HI = 12;
  localparam int POS_ETYPE_LO = 13;
  localparam int POS_VER_IHL  = 14;
  localparam int POS_TLEN_HI  = 16;
  localparam int POS_TLEN_LO  = 17;
  localparam int POS_FRAG_HI  = 20;
  localparam int POS_FRAG_LO  = 21;
  localparam int POS_PROTO    = 23;
  localparam int POS_TCP_BASE = 26;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_ETH_SHORT    = 4'd1,
    ST_NOT_IPV4     = 4'd2,
    ST_IP_SHORT     = 4'd3,
    ST_BAD_VERSION  = 4'd4,
    ST_IHL_SMALL    = 4'd5,
    ST_LEN_LT_IHL   = 4'd6,
    ST_FRAGMENT     = 4'd7,
    ST_BAD_PROTO    = 4'd8,
    ST_TCP_SHORT    = 4'd9,
    ST_TCP_OFF_SMALL = 4'd10,
    ST_TCP_OFF_OVER = 4'd11,
    ST_UDP_SHORT    = 4'd12
  } status_t;

  typedef enum logic [1:0] {
    L4_TCP  = 2'd0,
    L4_UDP  = 2'd1,
    L4_ICMP = 2'd2,
    L4_NONE = 2'd3
  } l4_kind_t;

  // header fields of one finished packet
  typedef struct packed {
    logic [15:0] eth_type;
    logic [3:0]  ip_version;
    logic [3:0]  ip_hdr_words;
    logic [15:0] ip_total_length;
    logic [15:0] frag_word;
    logic [7:0]  ip_protocol;
    logic [3:0]  tcp_offset_words;
    logic [15:0] pkt_len;
  } snap_t;

  // one result word
  typedef struct packed {
    status_t     status;
    l4_kind_t    l4_kind;
    logic [15:0] payload_offset;
    logic [15:0] packet_length;
  } res_t;

endpackage

@@ hw/rtl/eil4p_capture.sv @@
// Byte counter and header field capture for the header parser.
// Loads a snapshot of all fields on the final byte; depends on eil4p_pkg.
module eil4p_capture #(
  parameter int COUNT_BITS = eil4p_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              snap_valid,
  input  logic              snap_take,
  output eil4p_pkg::snap_t  snap
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic [15:0] etype_r, etype_nxt, etype_upd;
  logic [3:0]  ver_r, ver_nxt, ver_upd;
  logic [3:0]  ihl_r, ihl_nxt, ihl_upd;
  logic [15:0] tlen_r, tlen_nxt, tlen_upd;
  logic [15:0] frag_r, frag_nxt, frag_upd;
  logic [7:0]  proto_r, proto_nxt, proto_upd;
  logic [3:0]  toff_r, toff_nxt, toff_upd;
  logic        snap_valid_r, snap_valid_nxt;
  eil4p_pkg::snap_t snap_r, snap_nxt;
  logic        acc;
  logic [31:0] pos;
  logic [31:0] tcp_pos;
  logic [31:0] cnt_wide;

  // a new word is taken while the snapshot slot is free or being drained
  assign in_ready = !snap_valid_r || snap_take;
  assign acc      = in_valid && in_ready;

  // field capture at fixed byte positions
  always_comb begin
    pos      = 32'(cnt_r);
    tcp_pos  = 32'(eil4p_pkg::POS_TCP_BASE) + 32'({ihl_r, 2'b00});
    etype_upd = etype_r;
    ver_upd   = ver_r;
    ihl_upd   = ihl_r;
    tlen_upd  = tlen_r;
    frag_upd  = frag_r;
    proto_upd = proto_r;
    toff_upd  = toff_r;
    if (pos == 32'(eil4p_pkg::POS_ETYPE_HI)) etype_upd[15:8] = data_byte;
    if (pos == 32'(eil4p_pkg::POS_ETYPE_LO)) etype_upd[7:0]  = data_byte;
    if (pos == 32'(eil4p_pkg::POS_VER_IHL)) begin
      ver_upd = data_byte[7:4];
      ihl_upd = data_byte[3:0];
    end
    if (pos == 32'(eil4p_pkg::POS_TLEN_HI)) tlen_upd[15:8] = data_byte;
    if (pos == 32'(eil4p_pkg::POS_TLEN_LO)) tlen_upd[7:0]  = data_byte;
    if (pos == 32'(eil4p_pkg::POS_FRAG_HI)) frag_upd[15:8] = data_byte;
    if (pos == 32'(eil4p_pkg::POS_FRAG_LO)) frag_upd[7:0]  = data_byte;
    if (pos == 32'(eil4p_pkg::POS_PROTO))   proto_upd      = data_byte;
    if (pos == tcp_pos)                     toff_upd       = data_byte[7:4];
    // saturating count
    cnt_upd = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + COUNT_BITS'(1);
  end

  // state update, cleared after the final byte, and snapshot load
  always_comb begin
    cnt_nxt        = cnt_r;
    etype_nxt      = etype_r;
    ver_nxt        = ver_r;
    ihl_nxt        = ihl_r;
    tlen_nxt       = tlen_r;
    frag_nxt       = frag_r;
    proto_nxt      = proto_r;
    toff_nxt       = toff_r;
    snap_nxt       = snap_r;
    snap_valid_nxt = snap_valid_r && !snap_take;
    cnt_wide       = 32'(cnt_upd);
    if (acc) begin
      if (last_byte) begin
        cnt_nxt   = '0;
        etype_nxt = '0;
        ver_nxt   = '0;
        ihl_nxt   = '0;
        tlen_nxt  = '0;
        frag_nxt  = '0;
        proto_nxt = '0;
        toff_nxt  = '0;
        snap_nxt.eth_type         = etype_upd;
        snap_nxt.ip_version       = ver_upd;
        snap_nxt.ip_hdr_words     = ihl_upd;
        snap_nxt.ip_total_length  = tlen_upd;
        snap_nxt.frag_word        = frag_upd;
        snap_nxt.ip_protocol      = proto_upd;
        snap_nxt.tcp_offset_words = toff_upd;
        snap_nxt.pkt_len = (cnt_wide > 32'hFFFF) ? 16'hFFFF : cnt_wide[15:0];
        snap_valid_nxt = 1'b1;
      end else begin
        cnt_nxt   = cnt_upd;
        etype_nxt = etype_upd;
        ver_nxt   = ver_upd;
        ihl_nxt   = ihl_upd;
        tlen_nxt  = tlen_upd;
        frag_nxt  = frag_upd;
        proto_nxt = proto_upd;
        toff_nxt  = toff_upd;
      end
    end
  end

  // control and field registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      etype_r      <= '0;
      ver_r        <= '0;
      ihl_r        <= '0;
      tlen_r       <= '0;
      frag_r       <= '0;
      proto_r      <= '0;
      toff_r       <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      etype_r      <= etype_nxt;
      ver_r        <= ver_nxt;
      ihl_r        <= ihl_nxt;
      tlen_r       <= tlen_nxt;
      frag_r       <= frag_nxt;
      proto_r      <= proto_nxt;
      toff_r       <= toff_nxt;
      snap_valid_r <= snap_valid_nxt;
    end
  end

  // snapshot payload
  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

@@ hw/rtl/eil4p_eval.sv @@
// Header checks on a captured snapshot: status, layer-4 kind and payload offset.
// Purely combinational; depends on eil4p_pkg.
module eil4p_eval (
  input  eil4p_pkg::snap_t snap,
  output eil4p_pkg::res_t  res
);

  logic [15:0] rem;
  logic [15:0] rem_l4;
  logic [15:0] hlen;
  logic [15:0] th;
  logic [15:0] iplen;
  logic        is_frag;

  always_comb begin
    rem     = snap.pkt_len - eil4p_pkg::ETH_HDR_LEN;
    hlen    = 16'({snap.ip_hdr_words, 2'b00});
    th      = 16'({snap.tcp_offset_words, 2'b00});
    iplen   = (snap.ip_total_length > rem) ? rem : snap.ip_total_length;
    rem_l4  = rem - hlen;
    is_frag = snap.frag_word[eil4p_pkg::MF_BIT] || (snap.frag_word[12:0] != 13'd0);

    res.packet_length  = snap.pkt_len;
    res.payload_offset = 16'd0;
    res.l4_kind        = eil4p_pkg::L4_NONE;
    res.status         = eil4p_pkg::ST_OK;

    // checks in order, first failure wins
    priority if (snap.pkt_len < eil4p_pkg::ETH_HDR_LEN) begin
      res.status = eil4p_pkg::ST_ETH_SHORT;
    end else if (snap.eth_type != eil4p_pkg::ETHERTYPE_IPV4) begin
      res.status = eil4p_pkg::ST_NOT_IPV4;
    end else if (rem < eil4p_pkg::IP_MIN_HDR) begin
      res.status = eil4p_pkg::ST_IP_SHORT;
    end else if (snap.ip_version != eil4p_pkg::IP_VERSION_4) begin
      res.status = eil4p_pkg::ST_BAD_VERSION;
    end else if (hlen < eil4p_pkg::IP_MIN_HDR) begin
      res.status = eil4p_pkg::ST_IHL_SMALL;
    end else if (iplen < hlen) begin
      res.status = eil4p_pkg::ST_LEN_LT_IHL;
    end else if (is_frag) begin
      res.status = eil4p_pkg::ST_FRAGMENT;
    end else if (snap.ip_protocol == eil4p_pkg::PROTO_TCP) begin
      res.l4_kind = eil4p_pkg::L4_TCP;
      priority if (rem_l4 < eil4p_pkg::TCP_MIN_HDR) begin
        res.status = eil4p_pkg::ST_TCP_SHORT;
      end else if (th < eil4p_pkg::TCP_MIN_HDR) begin
        res.status = eil4p_pkg::ST_TCP_OFF_SMALL;
      end else if (th > rem_l4) begin
        res.status = eil4p_pkg::ST_TCP_OFF_OVER;
      end else begin
        res.payload_offset = eil4p_pkg::ETH_HDR_LEN + hlen + th;
      end
    end else if (snap.ip_protocol == eil4p_pkg::PROTO_UDP) begin
      res.l4_kind = eil4p_pkg::L4_UDP;
      if (rem_l4 < eil4p_pkg::UDP_HDR_LEN) begin
        res.status = eil4p_pkg::ST_UDP_SHORT;
      end else begin
        res.payload_offset = eil4p_pkg::ETH_HDR_LEN + hlen + eil4p_pkg::UDP_HDR_LEN;
      end
    end else if (snap.ip_protocol == eil4p_pkg::PROTO_ICMP) begin
      res.l4_kind        = eil4p_pkg::L4_ICMP;
      res.payload_offset = eil4p_pkg::ETH_HDR_LEN + hlen;
    end else begin
      res.status = eil4p_pkg::ST_BAD_PROTO;
    end
  end

endmodule

@@ hw/rtl/eth_ipv4_l4_header_parser.sv @@
// Ethernet / IPv4 / TCP-UDP header parser, top level.
// Instantiates eil4p_capture and eil4p_eval; depends on eil4p_pkg.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one frame byte per word,
//   starting at the Ethernet destination address; in_last_byte marks the
//   final byte. A word is taken whenever in_ready is high, so a line-rate
//   stream of one byte per cycle is sustained while in_ready stays high.
//   Result channel (out_valid / out_ready) carries one word per packet:
//   status, layer-4 kind, payload offset and the saturated byte count.
//   Result path: the snapshot register loads at the edge that takes the
//   final byte; the result register loads from the header checks once it
//   is free, and out_valid then rises.
//   Throughput: one byte per cycle while in_ready is high; a packet may
//   follow the previous one in the next cycle, even a one-byte packet.
//   Stall: when out_ready is low, the result holds and one more finished
//   packet can park in the snapshot register; in_ready drops only when
//   both are full. Bytes that do not end a packet still need in_ready.
//   Reset: clears the byte counter, all captured fields and both valids.
module eth_ipv4_l4_header_parser #(
  parameter int COUNT_BITS = eil4p_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [1:0]  out_l4_kind,
  output logic [15:0] out_payload_offset,
  output logic [15:0] out_packet_length
);

  eil4p_pkg::snap_t snap;
  eil4p_pkg::res_t  res;
  eil4p_pkg::res_t  res_r, res_nxt;
  logic             snap_valid;
  logic             snap_take;
  logic             out_free;
  logic             out_valid_r, out_valid_nxt;

  // byte counting and field capture
  eil4p_capture #(
    .COUNT_BITS(COUNT_BITS)
  ) u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (in_data_byte),
    .last_byte  (in_last_byte),
    .snap_valid (snap_valid),
    .snap_take  (snap_take),
    .snap       (snap)
  );

  // header checks
  eil4p_eval u_eval (
    .snap (snap),
    .res  (res)
  );

  // result register handshake
  assign out_free  = !out_valid_r || out_ready;
  assign snap_take = snap_valid && out_free;

  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (snap_take) begin
      res_nxt       = res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // result ports
  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_l4_kind        = res_r.l4_kind;
  assign out_payload_offset = res_r.payload_offset;
  assign out_packet_length  = res_r.packet_length;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the Ethernet / IPv4 / layer-4 header parser.
// Drives frame bytes with random idle gaps, predicts each packet result and compares.
// Depends on eil4p_pkg and eth_ipv4_l4_header_parser.
module tb;

  localparam int CNT_MAX = (1 << eil4p_pkg::COUNT_BITS_DEF) - 1;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_status;
  logic [1:0]  out_l4_kind;
  logic [15:0] out_payload_offset;
  logic [15:0] out_packet_length;

  // predicted results still in flight
  eil4p_pkg::res_t pending_results[$];
  int   errors;
  int   bytes_sent;
  int   frames_sent;
  bit   no_gaps;
  bit   long_hold;

  // header fields captured so far by the predictor
  int          hdr_count;
  logic [15:0] hdr_etype;
  logic [3:0]  hdr_version;
  logic [3:0]  hdr_ihl;
  logic [15:0] hdr_tlen;
  logic [15:0] hdr_frag;
  logic [7:0]  hdr_proto;
  logic [3:0]  hdr_tcp_off;

  eth_ipv4_l4_header_parser dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_l4_kind        (out_l4_kind),
    .out_payload_offset (out_payload_offset),
    .out_packet_length  (out_packet_length)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end

  // clear the captured header fields
  task automatic clear_headers();
    hdr_count   = 0;
    hdr_etype   = '0;
    hdr_version = '0;
    hdr_ihl     = '0;
    hdr_tlen    = '0;
    hdr_frag    = '0;
    hdr_proto   = '0;
    hdr_tcp_off = '0;
  endtask

  // header checks on the final byte, in order
  function automatic eil4p_pkg::res_t judge_headers();
    eil4p_pkg::res_t r;
    int   len;
    int   rem;
    int   hlen;
    int   iplen;
    int   th;
    len = (hdr_count > 65535) ? 65535 : hdr_count;
    r.status         = eil4p_pkg::ST_OK;
    r.l4_kind        = eil4p_pkg::L4_NONE;
    r.payload_offset = '0;
    r.packet_length  = 16'(len);
    rem   = len - int'(eil4p_pkg::ETH_HDR_LEN);
    hlen  = 4 * int'(hdr_ihl);
    iplen = int'(hdr_tlen);
    if (len < int'(eil4p_pkg::ETH_HDR_LEN)) r.status = eil4p_pkg::ST_ETH_SHORT;
    else if (hdr_etype != eil4p_pkg::ETHERTYPE_IPV4) r.status = eil4p_pkg::ST_NOT_IPV4;
    else if (rem < int'(eil4p_pkg::IP_MIN_HDR)) r.status = eil4p_pkg::ST_IP_SHORT;
    else if (hdr_version != eil4p_pkg::IP_VERSION_4) r.status = eil4p_pkg::ST_BAD_VERSION;
    else if (hlen < int'(eil4p_pkg::IP_MIN_HDR)) r.status = eil4p_pkg::ST_IHL_SMALL;
    else if (((iplen > rem) ? rem : iplen) < hlen) r.status = eil4p_pkg::ST_LEN_LT_IHL;
    else if (hdr_frag[eil4p_pkg::MF_BIT] || hdr_frag[12:0] != 13'd0) begin
      r.status = eil4p_pkg::ST_FRAGMENT;
    end else begin
      rem = rem - hlen;
      th  = 4 * int'(hdr_tcp_off);
      if (hdr_proto == eil4p_pkg::PROTO_TCP) begin
        r.l4_kind = eil4p_pkg::L4_TCP;
        if (rem < int'(eil4p_pkg::TCP_MIN_HDR)) r.status = eil4p_pkg::ST_TCP_SHORT;
        else if (th < int'(eil4p_pkg::TCP_MIN_HDR)) r.status = eil4p_pkg::ST_TCP_OFF_SMALL;
        else if (th > rem) r.status = eil4p_pkg::ST_TCP_OFF_OVER;
        else r.payload_offset = 16'(int'(eil4p_pkg::ETH_HDR_LEN) + hlen + th);
      end else if (hdr_proto == eil4p_pkg::PROTO_UDP) begin
        r.l4_kind = eil4p_pkg::L4_UDP;
        if (rem < int'(eil4p_pkg::UDP_HDR_LEN)) r.status = eil4p_pkg::ST_UDP_SHORT;
        else r.payload_offset = 16'(int'(eil4p_pkg::ETH_HDR_LEN) + hlen
                                    + int'(eil4p_pkg::UDP_HDR_LEN));
      end else if (hdr_proto == eil4p_pkg::PROTO_ICMP) begin
        r.l4_kind        = eil4p_pkg::L4_ICMP;
        r.payload_offset = 16'(int'(eil4p_pkg::ETH_HDR_LEN) + hlen);
      end else begin
        r.status = eil4p_pkg::ST_BAD_PROTO;
      end
    end
    // failed checks before layer 4 report no kind; all errors report offset 0
    if (r.status != eil4p_pkg::ST_OK) r.payload_offset = '0;
    return r;
  endfunction

  // advance the predictor by one accepted byte
  task automatic parse_byte(input logic [7:0] b, input logic last);
    case (hdr_count)
      eil4p_pkg::POS_ETYPE_HI: hdr_etype[15:8] = b;
      eil4p_pkg::POS_ETYPE_LO: hdr_etype[7:0]  = b;
      eil4p_pkg::POS_VER_IHL: begin
        hdr_version = b[7:4];
        hdr_ihl     = b[3:0];
      end
      eil4p_pkg::POS_TLEN_HI:  hdr_tlen[15:8] = b;
      eil4p_pkg::POS_TLEN_LO:  hdr_tlen[7:0]  = b;
      eil4p_pkg::POS_FRAG_HI:  hdr_frag[15:8] = b;
      eil4p_pkg::POS_FRAG_LO:  hdr_frag[7:0]  = b;
      eil4p_pkg::POS_PROTO:    hdr_proto      = b;
      default: ;
    endcase
    if (hdr_count == eil4p_pkg::POS_TCP_BASE + 4 * int'(hdr_ihl)) hdr_tcp_off = b[7:4];
    if (hdr_count < CNT_MAX) hdr_count++;
    if (last) begin
      pending_results.push_back(judge_headers());
      clear_headers();
    end
  endtask

  // offer one byte after a random gap and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    parse_byte(b, last);
    bytes_sent++;
  endtask

  // one frame of random bytes with the parsed header fields placed
  task automatic send_frame(input int len, input logic [15:0] etype,
                            input logic [7:0] ver_ihl, input logic [15:0] tlen,
                            input logic [15:0] frag, input logic [7:0] proto,
                            input logic [7:0] tcp_byte);
    logic [7:0] b;
    int         tcp_pos;
    tcp_pos = eil4p_pkg::POS_TCP_BASE + 4 * int'(ver_ihl[3:0]);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      case (i)
        eil4p_pkg::POS_ETYPE_HI: b = etype[15:8];
        eil4p_pkg::POS_ETYPE_LO: b = etype[7:0];
        eil4p_pkg::POS_VER_IHL:  b = ver_ihl;
        eil4p_pkg::POS_TLEN_HI:  b = tlen[15:8];
        eil4p_pkg::POS_TLEN_LO:  b = tlen[7:0];
        eil4p_pkg::POS_FRAG_HI:  b = frag[15:8];
        eil4p_pkg::POS_FRAG_LO:  b = frag[7:0];
        eil4p_pkg::POS_PROTO:    b = proto;
        default: ;
      endcase
      if (i == tcp_pos) b = tcp_byte;
      send_byte(b, i == len - 1);
    end
    frames_sent++;
  endtask

  // stop offering and wait until every predicted result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // frames too short for ethernet or ipv4, and a wrong ethertype
  task automatic test_ethernet_length();
    send_frame(1, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd20, 16'h0000,
               eil4p_pkg::PROTO_UDP, 8'h50);
    send_frame(13, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd20, 16'h0000,
               eil4p_pkg::PROTO_UDP, 8'h50);
    send_frame(14, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd20, 16'h0000,
               eil4p_pkg::PROTO_UDP, 8'h50);
    send_frame(33, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd20, 16'h0000,
               eil4p_pkg::PROTO_UDP, 8'h50);
    send_frame(42, 16'h86DD, 8'h45, 16'd28, 16'h0000, eil4p_pkg::PROTO_UDP, 8'h50);
    wait_drained();
  endtask

  // version, header length, total length and fragment checks
  task automatic test_ipv4_checks();
    send_frame(42, eil4p_pkg::ETHERTYPE_IPV4, 8'h65, 16'd28, 16'h0000,
               eil4p_pkg::PROTO_UDP, 8'h50);
    send_frame(42, eil4p_pkg::ETHERTYPE_IPV4, 8'h44, 16'd28, 16'h0000,
               eil4p_pkg::PROTO_UDP, 8'h50);
    send_frame(42, eil4p_pkg::ETHERTYPE_IPV4, 8'h40, 16'd28, 16'h0000,
               eil4p_pkg::PROTO_UDP, 8'h50);
    send_frame(42, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd19, 16'h0000,
               eil4p_pkg::PROTO_UDP, 8'h50);
    // total length is large but the frame ends before the options do
    send_frame(54, eil4p_pkg::ETHERTYPE_IPV4, 8'h4F, 16'd1500, 16'h0000,
               eil4p_pkg::PROTO_UDP, 8'h50);
    send_frame(42, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd28, 16'h2000,
               eil4p_pkg::PROTO_UDP, 8'h50);
    send_frame(42, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd28, 16'h0001,
               eil4p_pkg::PROTO_UDP, 8'h50);
    send_frame(42, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd28, 16'h1FFF,
               eil4p_pkg::PROTO_UDP, 8'h50);
    send_frame(42, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd28, 16'h4000,
               eil4p_pkg::PROTO_UDP, 8'h50);
    wait_drained();
  endtask

  // tcp, udp, icmp and unknown protocols, good and short
  task automatic test_layer4();
    send_frame(54, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd40, 16'h0000,
               eil4p_pkg::PROTO_TCP, 8'h50);
    send_frame(134, eil4p_pkg::ETHERTYPE_IPV4, 8'h4F, 16'd120, 16'h0000,
               eil4p_pkg::PROTO_TCP, 8'hF0);
    send_frame(53, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd39, 16'h0000,
               eil4p_pkg::PROTO_TCP, 8'h50);
    send_frame(54, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd40, 16'h0000,
               eil4p_pkg::PROTO_TCP, 8'h40);
    send_frame(54, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd40, 16'h0000,
               eil4p_pkg::PROTO_TCP, 8'h60);
    send_frame(42, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd28, 16'h0000,
               eil4p_pkg::PROTO_UDP, 8'h00);
    send_frame(41, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd27, 16'h0000,
               eil4p_pkg::PROTO_UDP, 8'h00);
    send_frame(34, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd20, 16'h0000,
               eil4p_pkg::PROTO_ICMP, 8'h00);
    send_frame(60, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd46, 16'h0000, 8'h00, 8'h50);
    send_frame(60, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd46, 16'h0000, 8'hFF, 8'h50);
    // link padding past the ip total length stays counted
    send_frame(60, eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd20, 16'h0000,
               eil4p_pkg::PROTO_UDP, 8'h00);
    wait_drained();
  endtask

  // all header fields at their extremes
  task automatic test_field_extremes();
    send_frame(60, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_frame(60, 16'h0000, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00);
    send_frame(60, eil4p_pkg::ETHERTYPE_IPV4, 8'h4F, 16'hFFFF, 16'h0000,
               eil4p_pkg::PROTO_ICMP, 8'hFF);
    wait_drained();
  endtask

  // receiver holds off while short frames stream in back to back
  task automatic test_backpressure();
    long_hold = 1'b1;
    no_gaps   = 1'b1;
    for (int i = 0; i < 60; i++) begin
      send_frame($urandom_range(1, 3), eil4p_pkg::ETHERTYPE_IPV4, 8'h45, 16'd20,
                 16'h0000, eil4p_pkg::PROTO_UDP, 8'h50);
    end
    no_gaps = 1'b0;
    wait_drained();
  endtask

  // mostly well-formed frames with random fields, some corrupt, some noise
  task automatic test_random_traffic();
    int          bytes_start;
    int          frames_start;
    int          ihl;
    int          toff;
    int          l4_len;
    int          len;
    logic [7:0]  proto;
    logic [15:0] etype;
    logic [3:0]  version;
    logic [15:0] tlen;
    logic [15:0] frag;
    bytes_start  = bytes_sent;
    frames_start = frames_sent;
    while (bytes_sent - bytes_start < 240 || frames_sent - frames_start < 6) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 4) == 0) begin
        send_frame($urandom_range(1, 64), 16'($urandom), 8'($urandom), 16'($urandom),
                   16'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
        toff = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 5;
        case ($urandom_range(0, 3))
          0: begin
            proto  = eil4p_pkg::PROTO_TCP;
            l4_len = 4 * ((toff < 5) ? 5 : toff);
          end
          1: begin
            proto  = eil4p_pkg::PROTO_UDP;
            l4_len = int'(eil4p_pkg::UDP_HDR_LEN);
          end
          2: begin
            proto  = eil4p_pkg::PROTO_ICMP;
            l4_len = 0;
          end
          default: begin
            proto  = 8'($urandom);
            l4_len = 8;
          end
        endcase
        len = int'(eil4p_pkg::ETH_HDR_LEN) + 4 * ihl + l4_len + $urandom_range(0, 12);
        if ($urandom_range(0, 7) == 0) len = len - $urandom_range(1, 12);
        if ($urandom_range(0, 15) == 0) ihl = $urandom_range(0, 4);
        etype   = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                               : eil4p_pkg::ETHERTYPE_IPV4;
        version = ($urandom_range(0, 15) == 0) ? 4'($urandom) : eil4p_pkg::IP_VERSION_4;
        tlen    = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                              : 16'(len - int'(eil4p_pkg::ETH_HDR_LEN));
        frag    = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                              : ($urandom_range(0, 1) ? 16'h4000 : 16'h0000);
        send_frame(len, etype, {version, 4'(ihl)}, tlen, frag, proto,
                   {4'(toff), 4'($urandom)});
      end
    end
    no_gaps = 1'b0;
    wait_drained();
  endtask

  // result receiver with random stalls and one long hold
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold) begin
        stall     = 200;
        long_hold = 1'b0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 9);
      end
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare each accepted result word with the oldest prediction
  initial begin
    eil4p_pkg::res_t exp_r;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word, status %0d", $time, out_status);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_status !== exp_r.status) begin
            $display("%0t: status expected %0d got %0d", $time, exp_r.status, out_status);
            errors++;
          end
          if (out_l4_kind !== exp_r.l4_kind) begin
            $display("%0t: l4_kind expected %0d got %0d", $time, exp_r.l4_kind,
                     out_l4_kind);
            errors++;
          end
          if (out_payload_offset !== exp_r.payload_offset) begin
            $display("%0t: payload_offset expected %0d got %0d", $time,
                     exp_r.payload_offset, out_payload_offset);
            errors++;
          end
          if (out_packet_length !== exp_r.packet_length) begin
            $display("%0t: packet_length expected %0d got %0d", $time,
                     exp_r.packet_length, out_packet_length);
            errors++;
          end
        end
      end
    end
  end

  // reset, test sequence and final verdict
  initial begin
    errors       = 0;
    bytes_sent   = 0;
    frames_sent  = 0;
    no_gaps      = 1'b0;
    long_hold    = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    in_last_byte = 1'b0;
    clear_headers();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_ethernet_length();
    test_ipv4_checks();
    test_layer4();
    test_field_extremes();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/eil4p_pkg.sv
hw/rtl/eil4p_capture.sv
hw/rtl/eil4p_eval.sv
hw/rtl/eth_ipv4_l4_header_parser.sv
tb/tb.sv
